// File: rtl/at_command_line_decoder_assert.svh
// Assertion macros for the AT command line decoder checker
`ifndef AT_COMMAND_LINE_DECODER_ASSERT_SVH
`define AT_COMMAND_LINE_DECODER_ASSERT_SVH
// Implication checked on every rising clock edge, outside reset
`define ACLD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Implication with the consequent checked in the next cycle
`define ACLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: rtl/acld_pkg.sv
// ----------------------------------------------------------------------------
// acld_pkg
// Types and constants shared by the AT command line decoder modules.
// ----------------------------------------------------------------------------
package acld_pkg;

    localparam int LINE_BUFFER_BYTES = 48;
    localparam int MAX_KEPT          = LINE_BUFFER_BYTES - 1;
    // longest valid command: "AT+UART2&3=OFF" is 14 characters
    localparam int MATCH_LEN         = 16;
    localparam int CNT_W             = $clog2(LINE_BUFFER_BYTES);

    // command kinds
    localparam logic [3:0] K_SENSE  = 4'd0;
    localparam logic [3:0] K_FAULT  = 4'd1;
    localparam logic [3:0] K_MOTORQ = 4'd2;
    localparam logic [3:0] K_BRIDGE = 4'd3;
    localparam logic [3:0] K_LED    = 4'd4;
    localparam logic [3:0] K_MODE   = 4'd5;
    localparam logic [3:0] K_NMOS1  = 4'd6;
    localparam logic [3:0] K_NMOS2  = 4'd7;
    localparam logic [3:0] K_UVLO   = 4'd8;

    localparam logic [1:0] T_UART2 = 2'd0;
    localparam logic [1:0] T_UART3 = 2'd1;
    localparam logic [1:0] T_BOTH  = 2'd2;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       end_of_line;
    } t_in_item;

    typedef struct packed {
        logic       accepted;
        logic [3:0] command_kind;
        logic [1:0] bridge_target;
        logic       switch_on;
        logic [2:0] motor_mode;
    } t_out_item;

    // completed line handed from front to back
    typedef struct packed {
        logic [MATCH_LEN-1:0][7:0] text;
        logic [CNT_W-1:0]          count;
    } t_line;

endpackage

// File: rtl/acld_front.sv
// ----------------------------------------------------------------------------
// acld_front
// Filters incoming bytes and collects the first characters of a line.
// ----------------------------------------------------------------------------
module acld_front import acld_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_ready,
    output logic     o_line_valid,
    output t_line    o_line,
    input  logic     i_line_ready
);
    logic [MATCH_LEN-1:0][7:0] r_text;
    logic [CNT_W-1:0]          r_count;
    logic                      r_ended;
    logic                      keep;
    logic                      acc;
    logic [CNT_W-1:0]          n_count;

    assign o_ready = i_line_ready;
    assign acc     = i_valid && o_ready;

    // byte classification
    always_comb begin
        keep = !r_ended && i_item.line_byte != 8'h00 && i_item.line_byte != 8'h0d &&
               i_item.line_byte != 8'h0a && i_item.line_byte != 8'h20 &&
               i_item.line_byte != 8'h09 && r_count < CNT_W'(MAX_KEPT);
        n_count = keep ? r_count + CNT_W'(1) : r_count;
        o_line.text = r_text;
        if (keep && r_count < CNT_W'(MATCH_LEN)) begin
            o_line.text[r_count[$clog2(MATCH_LEN)-1:0]] = i_item.line_byte;
        end
        o_line.count = n_count;
        o_line_valid = acc && i_item.end_of_line;
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ended <= 1'b0;
        end else if (acc) begin
            if (i_item.end_of_line) begin
                r_count <= '0;
                r_ended <= 1'b0;
            end else begin
                r_count <= n_count;
                if (!r_ended && i_item.line_byte == 8'h00) r_ended <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_text <= o_line.text;
    end
endmodule

// File: rtl/acld_back.sv
// ----------------------------------------------------------------------------
// acld_back
// Two-entry line queue, then match against the command set into an output
// register.
// ----------------------------------------------------------------------------
module acld_back import acld_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_line_valid,
    input  t_line     i_line,
    output logic      o_line_ready,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_ready
);
    t_line     r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic       pop;
    t_out_item  dec;
    t_line      hd;

    function automatic logic eq(t_line l, string s, int off);
        logic ok;
        ok = 1'b1;
        for (int k = 0; k < MATCH_LEN; k++) begin
            if (k >= off && k - off < s.len()) begin
                if (l.text[k] != s[k-off]) ok = 1'b0;
            end
        end
        return ok && (int'(l.count) == off + s.len());
    endfunction

    assign hd           = r_q[r_rd];
    assign o_line_ready = r_cnt != 2'd2;
    assign pop          = r_cnt != 2'd0 && (!o_valid || i_ready);

    // command match on queue head
    always_comb begin
        dec = '0;
        if (eq(hd, "AT+SENSE?", 0))      dec = '{1'b1, K_SENSE, T_UART2, 1'b0, 3'd0};
        if (eq(hd, "AT+FAULT?", 0))      dec = '{1'b1, K_FAULT, T_UART2, 1'b0, 3'd0};
        if (eq(hd, "AT+MOTOR?", 0))      dec = '{1'b1, K_MOTORQ, T_UART2, 1'b0, 3'd0};
        if (eq(hd, "AT+UART2=ON", 0))    dec = '{1'b1, K_BRIDGE, T_UART2, 1'b1, 3'd0};
        if (eq(hd, "AT+UART2=OFF", 0))   dec = '{1'b1, K_BRIDGE, T_UART2, 1'b0, 3'd0};
        if (eq(hd, "AT+UART3=ON", 0))    dec = '{1'b1, K_BRIDGE, T_UART3, 1'b1, 3'd0};
        if (eq(hd, "AT+UART3=OFF", 0))   dec = '{1'b1, K_BRIDGE, T_UART3, 1'b0, 3'd0};
        if (eq(hd, "AT+UART2&3=ON", 0))  dec = '{1'b1, K_BRIDGE, T_BOTH, 1'b1, 3'd0};
        if (eq(hd, "AT+UART2&3=OFF", 0)) dec = '{1'b1, K_BRIDGE, T_BOTH, 1'b0, 3'd0};
        if (eq(hd, "AT+UART23=ON", 0))   dec = '{1'b1, K_BRIDGE, T_BOTH, 1'b1, 3'd0};
        if (eq(hd, "AT+UART23=OFF", 0))  dec = '{1'b1, K_BRIDGE, T_BOTH, 1'b0, 3'd0};
        if (eq(hd, "AT+LED=ON", 0))      dec = '{1'b1, K_LED, T_UART2, 1'b1, 3'd0};
        if (eq(hd, "AT+LED=OFF", 0))     dec = '{1'b1, K_LED, T_UART2, 1'b0, 3'd0};
        if (eq(hd, "AT+NMOS1=ON", 0))    dec = '{1'b1, K_NMOS1, T_UART2, 1'b1, 3'd0};
        if (eq(hd, "AT+NMOS1=OFF", 0))   dec = '{1'b1, K_NMOS1, T_UART2, 1'b0, 3'd0};
        if (eq(hd, "AT+NMOS2=ON", 0))    dec = '{1'b1, K_NMOS2, T_UART2, 1'b1, 3'd0};
        if (eq(hd, "AT+NMOS2=OFF", 0))   dec = '{1'b1, K_NMOS2, T_UART2, 1'b0, 3'd0};
        if (eq(hd, "AT+UVLO=ON", 0))     dec = '{1'b1, K_UVLO, T_UART2, 1'b1, 3'd0};
        if (eq(hd, "AT+UVLO=OFF", 0))    dec = '{1'b1, K_UVLO, T_UART2, 1'b0, 3'd0};
        if (eq(hd, "AT+MOTOR=SLEEP", 0)) dec = '{1'b1, K_MODE, T_UART2, 1'b0, 3'd0};
        if (eq(hd, "AT+MOTOR=WAKE", 0))  dec = '{1'b1, K_MODE, T_UART2, 1'b0, 3'd1};
        if (eq(hd, "AT+MOTOR=FWD", 0))   dec = '{1'b1, K_MODE, T_UART2, 1'b0, 3'd2};
        if (eq(hd, "AT+MOTOR=REV", 0))   dec = '{1'b1, K_MODE, T_UART2, 1'b0, 3'd3};
        if (eq(hd, "AT+MOTOR=BRAKE", 0)) dec = '{1'b1, K_MODE, T_UART2, 1'b0, 3'd4};
        if (eq(hd, "AT+MOTOR=STOP", 0))  dec = '{1'b1, K_MODE, T_UART2, 1'b0, 3'd5};
    end

    // queue pointers and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_rd    <= 1'b0;
            r_wr    <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (i_line_valid && o_line_ready) r_wr <= !r_wr;
            if (pop) r_rd <= !r_rd;
            r_cnt <= r_cnt + 2'((i_line_valid && o_line_ready) ? 1 : 0) - 2'(pop ? 1 : 0);
            if (pop) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_line_valid && o_line_ready) r_q[r_wr] <= i_line;
        if (pop) o_item <= dec;
    end
endmodule

// File: rtl/at_command_line_decoder.sv
// ----------------------------------------------------------------------------
// at_command_line_decoder
// Collects an AT command line byte by byte and decodes it on the final byte.
// ----------------------------------------------------------------------------
//  channel | signals                  | payload
//  in      | i_valid / o_ready        | t_in_item  (line_byte, end_of_line)
//  out     | o_valid / i_ready        | t_out_item (decoded command)
//
// One byte per cycle. The final byte's line enters a two-line queue at its
// accepting edge; with an idle output the result is valid after the next edge.
// Input stalls only when the queue is full behind a stalled output.
// Reset clears the line count and queue; no clearing pass.
module at_command_line_decoder import acld_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    output logic      o_ready,
    output logic      o_valid,
    output t_out_item o_item,
    input  logic      i_ready
);
    logic  line_valid;
    logic  line_ready;
    t_line line;

    acld_front u_front (
        .i_clk, .i_rst_n, .i_valid, .i_item, .o_ready,
        .o_line_valid(line_valid), .o_line(line), .i_line_ready(line_ready)
    );

    acld_back u_back (
        .i_clk, .i_rst_n, .i_line_valid(line_valid), .i_line(line),
        .o_line_ready(line_ready), .o_valid, .o_item, .i_ready
    );
endmodule

// File: rtl/acld_checker.sv
// ----------------------------------------------------------------------------
// acld_checker
// Port-level checks on the AT command line decoder.
// ----------------------------------------------------------------------------
`include "at_command_line_decoder_assert.svh"
module acld_checker import acld_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input t_in_item  i_item,
    input logic      o_ready,
    input logic      o_valid,
    input t_out_item o_item,
    input logic      i_ready
);
    // output held while stalled
    `ACLD_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_item))
    // a rejected line carries all-zero fields
    `ACLD_ASSERT_IMP(a_zero, i_clk, i_rst_n, o_valid && !o_item.accepted, o_item == '0)
    // kinds stay in range
    `ACLD_ASSERT_IMP(a_kind, i_clk, i_rst_n, o_valid, o_item.command_kind <= K_UVLO)
    // a final byte accepted with idle output gives a result once its line has passed the queue and output register
    `ACLD_ASSERT_NEXT(a_lat, i_clk, i_rst_n,
        i_valid && o_ready && i_item.end_of_line && !o_valid, ##1 o_valid)
endmodule

bind at_command_line_decoder acld_checker u_acld_checker (.*);

// File: dv/at_command_line_decoder_checker.sv
// ----------------------------------------------------------------------------
// at_command_line_decoder_checker
// Watches both channels of the AT command line decoder, predicts the decoded
// command of every completed line and compares it with each output transaction.
// ----------------------------------------------------------------------------
module at_command_line_decoder_checker import acld_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  t_in_item  i_item,
    input  logic      i_ready_in,
    input  logic      i_valid_out,
    input  t_out_item i_item_out,
    input  logic      i_ready,
    output int        o_errors,
    output int        o_pending,
    output int        o_commands
);
    timeunit 1ns;
    timeprecision 1ps;

    byte unsigned line_text[$];
    bit           line_closed;
    t_out_item    expected_cmds[$];

    // kept text equals literal s from offset off to the end
    function automatic bit text_is(int off, string s);
        if (line_text.size() - off != s.len()) return 1'b0;
        for (int i = 0; i < s.len(); i++)
            if (line_text[off + i] != s[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit text_starts(string s);
        if (line_text.size() < s.len()) return 1'b0;
        for (int i = 0; i < s.len(); i++)
            if (line_text[i] != s[i]) return 1'b0;
        return 1'b1;
    endfunction

    function automatic t_out_item decode_line();
        t_out_item r;
        string     pre [9];
        logic [3:0] knd [9];
        logic [1:0] tgt [9];
        string     modes [6];
        r = '0;
        pre  = '{"AT+UART2=", "AT+UART3=", "AT+UART2&3=", "AT+UART23=", "AT+LED=",
                 "AT+MOTOR=", "AT+NMOS1=", "AT+NMOS2=", "AT+UVLO="};
        knd  = '{K_BRIDGE, K_BRIDGE, K_BRIDGE, K_BRIDGE, K_LED, K_MODE,
                 K_NMOS1, K_NMOS2, K_UVLO};
        tgt  = '{T_UART2, T_UART3, T_BOTH, T_BOTH, T_UART2, T_UART2,
                 T_UART2, T_UART2, T_UART2};
        modes = '{"SLEEP", "WAKE", "FWD", "REV", "BRAKE", "STOP"};
        if (!text_starts("AT+")) return r;
        if (text_is(0, "AT+SENSE?")) begin r.accepted = 1; r.command_kind = K_SENSE;  return r; end
        if (text_is(0, "AT+FAULT?")) begin r.accepted = 1; r.command_kind = K_FAULT;  return r; end
        if (text_is(0, "AT+MOTOR?")) begin r.accepted = 1; r.command_kind = K_MOTORQ; return r; end
        for (int i = 0; i < 9; i++) begin
            if (!text_starts(pre[i])) continue;
            if (knd[i] == K_MODE) begin
                for (int m = 0; m < 6; m++)
                    if (text_is(pre[i].len(), modes[m])) begin
                        r.accepted = 1; r.command_kind = K_MODE; r.motor_mode = 3'(m);
                        return r;
                    end
            end else if (text_is(pre[i].len(), "ON") || text_is(pre[i].len(), "OFF")) begin
                r.accepted      = 1;
                r.command_kind  = knd[i];
                r.bridge_target = tgt[i];
                r.switch_on     = text_is(pre[i].len(), "ON");
                return r;
            end
        end
        return r;
    endfunction

    // predict on input transactions, compare on output transactions
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            line_text.delete();
            line_closed = 0;
        end else begin
            if (i_valid && i_ready_in) begin
                if (!line_closed) begin
                    if (i_item.line_byte == 8'h00) line_closed = 1;
                    else if (!(i_item.line_byte inside {8'h0d, 8'h0a, 8'h20, 8'h09})
                             && line_text.size() < MAX_KEPT)
                        line_text.push_back(i_item.line_byte);
                end
                if (i_item.end_of_line) begin
                    expected_cmds.push_back(decode_line());
                    line_text.delete();
                    line_closed = 0;
                end
            end
            if (i_valid_out && i_ready) begin
                o_commands++;
                if (expected_cmds.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10) $display("unexpected command %h", i_item_out);
                end else begin
                    want = expected_cmds.pop_front();
                    if (want !== i_item_out) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display("mismatch: expected acc=%0d kind=%0d tgt=%0d on=%0d mode=%0d, got acc=%0d kind=%0d tgt=%0d on=%0d mode=%0d",
                                want.accepted, want.command_kind, want.bridge_target,
                                want.switch_on, want.motor_mode, i_item_out.accepted,
                                i_item_out.command_kind, i_item_out.bridge_target,
                                i_item_out.switch_on, i_item_out.motor_mode);
                    end
                end
            end
        end
        o_pending = expected_cmds.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_commands = 0;
    end
endmodule

// File: dv/at_command_line_decoder_test.sv
// ----------------------------------------------------------------------------
// at_command_line_decoder_test
// Drives directed and random AT command lines into the decoder with random
// idling on both channels (none in the last random phase); the checker predicts and compares each command.
// ----------------------------------------------------------------------------
module at_command_line_decoder_test import acld_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 5000;

    logic      i_clk = 0;
    logic      i_rst_n = 0;
    logic      i_valid = 0;
    t_in_item  i_item = '0;
    logic      o_ready;
    logic      o_valid;
    t_out_item o_item;
    logic      i_ready = 0;
    int        errors, pending, commands;
    int        send_idle_pct = 28, recv_idle_pct = 55;
    int        bytes_sent = 0, idle_cycles = 0;
    bit        draining = 0;

    always #5 i_clk = ~i_clk;

    at_command_line_decoder dut (.*);

    at_command_line_decoder_checker chk (
        .i_clk, .i_rst_n, .i_valid, .i_item, .i_ready_in(o_ready),
        .i_valid_out(o_valid), .i_item_out(o_item), .i_ready,
        .o_errors(errors), .o_pending(pending), .o_commands(commands));

    // receiver readiness
    always @(posedge i_clk)
        i_ready <= !draining && ($urandom_range(99) < recv_idle_pct) ? 1'b0 : 1'b1;

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("watchdog expired");
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one byte transaction, with optional idle cycles before it
    task automatic send_byte(byte unsigned b, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_item  <= '{line_byte: b, end_of_line: last};
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    task automatic send_line(string s, bit zero_last = 0);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], !zero_last && i == s.len() - 1);
        if (zero_last || s.len() == 0) send_byte(8'h00, 1);
    endtask

    function automatic string pick_command();
        string c [20];
        c = '{"AT+SENSE?", "AT+FAULT?", "AT+MOTOR?", "AT+UART2=ON", "AT+UART3=OFF",
              "AT+UART2&3=ON", "AT+UART23=OFF", "AT+LED=ON", "AT+LED=OFF",
              "AT+MOTOR=SLEEP", "AT+MOTOR=WAKE", "AT+MOTOR=FWD", "AT+MOTOR=REV",
              "AT+MOTOR=BRAKE", "AT+MOTOR=STOP", "AT+NMOS1=ON", "AT+NMOS2=OFF",
              "AT+UVLO=ON", "AT+UVLO=OFF", "AT+UART2=OFF"};
        return c[$urandom_range(19)];
    endfunction

    // valid command, mutated, truncated, extended or a noise line, optionally padded with whitespace
    function automatic string random_line();
        string s, t;
        int    kind;
        byte unsigned ws [4];
        ws = '{8'h0d, 8'h0a, 8'h20, 8'h09};
        s = pick_command();
        kind = $urandom_range(99);
        if (kind < 15) begin
            s[$urandom_range(s.len() - 1)] = 8'($urandom_range(1, 255));
        end else if (kind < 25) begin
            s = s.substr(0, $urandom_range(s.len() - 1));
        end else if (kind < 35) begin
            t = "";
            for (int i = $urandom_range(1, 60); i > 0; i--)
                t = {t, string'(8'($urandom_range(1, 255)))};
            s = t;
        end else if (kind < 45) begin
            s = {s, string'(8'($urandom_range(33, 126)))};
        end
        if ($urandom_range(3) == 0) begin
            t = "";
            for (int i = 0; i < s.len(); i++) begin
                if ($urandom_range(4) == 0) t = {t, string'(ws[$urandom_range(3)])};
                t = {t, string'(s[i])};
            end
            s = {t, string'(ws[$urandom_range(3)])};
        end
        return s;
    endfunction

    // stop sending and wait for every predicted command to come out
    task automatic wait_drained();
        i_valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        string s;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed lines
        send_line("AT+SENSE?");
        send_line("AT+FAULT?");
        send_line("AT+MOTOR?");
        send_line("AT+UART2=ON");
        send_line("AT+UART3=OFF");
        send_line("AT+UART2&3=ON");
        send_line("AT+UART23=OFF");
        send_line("AT+LED = ON\r\n");
        send_line("AT+NMOS1=OFF");
        send_line("AT+NMOS2=ON");
        send_line("AT+UVLO=ON");
        send_line("AT+MOTOR=SLEEP");
        send_line("AT+MOTOR=\tBRAKE", 1);
        send_line("AT+MOTOR=STOP");
        send_line("at+sense?");
        send_line("AT");
        send_line("");
        send_line("AT+LED=ONN");
        send_line({"AT+SENSE?", string'(8'h00), "ZZZ"});
        send_line("AT+UVLO=OFFAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAAA");
        send_line({string'(8'hff), string'(8'h80), "AT+LED=ON"});
        wait_drained();

        // random phases: receiver-heavy idling, sender-heavy, then none
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 55 : 0;
            recv_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 28 : 0;
            for (int n = 0; n < 19; n++) begin
                s = random_line();
                send_line(s, $urandom_range(7) == 0);
            end
            wait_drained();
        end

        wait_drained();
        draining = 1;
        repeat (20) @(posedge i_clk);
        $display("Sent %0d bytes, checked %0d commands across three idling phases.",
                 bytes_sent, commands);
        if (errors == 0 && pending == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
